@@ rtl/tbp_pkg.sv @@
package tbp_pkg;

	localparam int HIST_BITS     = 14;
	localparam int SEL_PC_BITS   = 7;
	localparam int CHOOSER_BITS  = 10;
	localparam int SEL_HIST_BITS = (HIST_BITS > SEL_PC_BITS) ? (HIST_BITS - SEL_PC_BITS) : 0;
	localparam int CLR_BITS      = (HIST_BITS > CHOOSER_BITS) ? HIST_BITS : CHOOSER_BITS;

	localparam logic [31:0] SEL_PC_MASK   = 32'((64'd1 << SEL_PC_BITS) - 64'd1);
	localparam logic [31:0] SEL_HIST_MASK = 32'((64'd1 << SEL_HIST_BITS) - 64'd1);

	localparam logic [1:0] MODE_ALWAYS     = 2'd0;
	localparam logic [1:0] MODE_GSHARE     = 2'd1;
	localparam logic [1:0] MODE_GSELECT    = 2'd2;
	localparam logic [1:0] MODE_TOURNAMENT = 2'd3;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	typedef logic [1:0]              ctr_t;
	typedef logic [HIST_BITS-1:0]    pht_idx_t;
	typedef logic [CHOOSER_BITS-1:0] cho_idx_t;

	localparam ctr_t CTR_INIT = 2'd2;

	typedef struct packed {
		logic     re;
		logic     we;
		pht_idx_t addr;
		ctr_t     wdata;
	} pht_req_t;

	typedef struct packed {
		logic     re;
		logic     we;
		cho_idx_t addr;
		ctr_t     wdata;
	} cho_req_t;

	typedef struct packed {
		logic valid;
		logic taken;
	} res_t;

	function automatic ctr_t ctr_train(input ctr_t c, input logic up);
		ctr_t r;
		r = c;
		if (up) begin
			if (c != 2'd3) r = c + 2'd1;
		end else begin
			if (c != 2'd0) r = c - 2'd1;
		end
		return r;
	endfunction

	function automatic pht_idx_t xor_slot(input logic [31:0] pc, input pht_idx_t hist);
		return pc[HIST_BITS-1:0] ^ hist;
	endfunction

	function automatic pht_idx_t concat_slot(input logic [31:0] pc, input pht_idx_t hist);
		logic [31:0] t;
		t = ((pc & SEL_PC_MASK) << SEL_HIST_BITS) | (32'(hist) & SEL_HIST_MASK);
		return t[HIST_BITS-1:0];
	endfunction

endpackage

@@ rtl/tournament_branch_predictor_unit.sv @@
// A transaction accepted in the idle state reads the counter tables into the RAM output
// registers, is resolved in the execute state and lands in the registered output slot.
// Input stalls until the execute state is left, so one transaction is taken at a time; the
// counter tables are read in the accept cycle and written back in the following cycle through a single port each.
// Reset: history, latched guesses and mode clear at once; the counter tables are then
// swept to weakly taken, address by address, during which input is stalled.
module tournament_branch_predictor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] branch_pc,
	input  logic        resolved_taken,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        predicted_taken,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data
);
	import tbp_pkg::*;

	pht_req_t xor_req;
	pht_req_t cat_req;
	cho_req_t cho_req;
	ctr_t     xor_rdata;
	ctr_t     cat_rdata;
	ctr_t     cho_rdata;
	res_t     res;
	logic     out_valid_q;
	logic     out_taken_q;

	tbp_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.branch_pc      (branch_pc),
		.resolved_taken (resolved_taken),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_busy       (out_valid_q & out_stall),
		.xor_rdata      (xor_rdata),
		.cat_rdata      (cat_rdata),
		.cho_rdata      (cho_rdata),
		.xor_req        (xor_req),
		.cat_req        (cat_req),
		.cho_req        (cho_req),
		.res            (res)
	);

	tbp_ram #(.ADDR_W(HIST_BITS), .DATA_W(2)) u_xor_ram (
		.clk   (clk),
		.re    (xor_req.re),
		.we    (xor_req.we),
		.addr  (xor_req.addr),
		.wdata (xor_req.wdata),
		.rdata (xor_rdata)
	);

	tbp_ram #(.ADDR_W(HIST_BITS), .DATA_W(2)) u_cat_ram (
		.clk   (clk),
		.re    (cat_req.re),
		.we    (cat_req.we),
		.addr  (cat_req.addr),
		.wdata (cat_req.wdata),
		.rdata (cat_rdata)
	);

	tbp_ram #(.ADDR_W(CHOOSER_BITS), .DATA_W(2)) u_cho_ram (
		.clk   (clk),
		.re    (cho_req.re),
		.we    (cho_req.we),
		.addr  (cho_req.addr),
		.wdata (cho_req.wdata),
		.rdata (cho_rdata)
	);

	// output slot is always free when a result arrives: input stalls while it is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) out_taken_q <= res.taken;
	end

	assign out_valid       = out_valid_q;
	assign predicted_taken = out_taken_q;

endmodule

@@ rtl/tbp_ram.sv @@
module tbp_ram #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 2
) (
	input  logic              clk,
	input  logic              re,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rdata <= mem[addr];
	end

endmodule

@@ rtl/tbp_engine.sv @@
module tbp_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [31:0]         branch_pc,
	input  logic                resolved_taken,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  logic                out_busy,
	input  tbp_pkg::ctr_t       xor_rdata,
	input  tbp_pkg::ctr_t       cat_rdata,
	input  tbp_pkg::ctr_t       cho_rdata,
	output tbp_pkg::pht_req_t   xor_req,
	output tbp_pkg::pht_req_t   cat_req,
	output tbp_pkg::cho_req_t   cho_req,
	output tbp_pkg::res_t       res
);
	import tbp_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]          state_q;
	logic [CLR_BITS-1:0] clr_q;
	pht_idx_t            hist_q;
	logic [1:0]          mode_q;
	logic                last_x_q;
	logic                last_c_q;

	logic     op_s1;
	logic     taken_s1;
	pht_idx_t xor_idx_s1;
	pht_idx_t cat_idx_s1;
	cho_idx_t cho_idx_s1;

	logic     accept;
	pht_idx_t xor_idx;
	pht_idx_t cat_idx;
	logic     gx;
	logic     gc;
	logic     pick;
	logic     train_en;

	assign in_stall = (state_q != ST_IDLE) | out_busy;
	assign accept   = in_valid & ~in_stall;
	assign xor_idx  = xor_slot(branch_pc, hist_q);
	assign cat_idx  = concat_slot(branch_pc, hist_q);
	assign gx       = xor_rdata[1];
	assign gc       = cat_rdata[1];
	assign train_en = (op_s1 == OP_UPDATE) && (mode_q != MODE_ALWAYS);

	always_comb begin
		unique case (mode_q)
			MODE_GSHARE:     pick = gx;
			MODE_GSELECT:    pick = gc;
			MODE_TOURNAMENT: pick = cho_rdata[1] ? gc : gx;
			default:         pick = 1'b1;
		endcase
	end

	always_comb begin
		xor_req = '0;
		cat_req = '0;
		cho_req = '0;
		res     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				xor_req.we    = 1'b1;
				xor_req.addr  = clr_q[HIST_BITS-1:0];
				xor_req.wdata = CTR_INIT;
				cat_req.we    = 1'b1;
				cat_req.addr  = clr_q[HIST_BITS-1:0];
				cat_req.wdata = CTR_INIT;
				cho_req.we    = 1'b1;
				cho_req.addr  = clr_q[CHOOSER_BITS-1:0];
				cho_req.wdata = CTR_INIT;
			end
			ST_IDLE: begin
				xor_req.re   = accept;
				xor_req.addr = xor_idx;
				cat_req.re   = accept;
				cat_req.addr = cat_idx;
				cho_req.re   = accept;
				cho_req.addr = branch_pc[CHOOSER_BITS-1:0];
			end
			ST_EXEC: begin
				xor_req.we    = train_en;
				xor_req.addr  = xor_idx_s1;
				xor_req.wdata = ctr_train(xor_rdata, taken_s1);
				cat_req.we    = train_en;
				cat_req.addr  = cat_idx_s1;
				cat_req.wdata = ctr_train(cat_rdata, taken_s1);
				// chooser moves only when the components disagreed
				cho_req.we    = train_en && (last_x_q != last_c_q);
				cho_req.addr  = cho_idx_s1;
				cho_req.wdata = ctr_train(cho_rdata, last_c_q == taken_s1);
				res.valid     = 1'b1;
				res.taken     = (op_s1 == OP_PREDICT) ? pick : 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			taken_s1   <= resolved_taken;
			xor_idx_s1 <= xor_idx;
			cat_idx_s1 <= cat_idx;
			cho_idx_s1 <= branch_pc[CHOOSER_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			hist_q   <= '0;
			mode_q   <= MODE_ALWAYS;
			last_x_q <= 1'b0;
			last_c_q <= 1'b0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (op_s1 == OP_PREDICT) begin
						last_x_q <= gx;
						last_c_q <= gc;
					end else if (train_en) begin
						hist_q <= {hist_q[HIST_BITS-2:0], taken_s1};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/tbp_direction_checker.sv @@
`timescale 1ns / 100ps
module tbp_direction_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [31:0] branch_pc,
	input  logic        resolved_taken,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        predicted_taken,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	output int          mismatches,
	output int          pending
);
	import tbp_pkg::*;

	ctr_t       xor_tbl  [1 << HIST_BITS];
	ctr_t       cat_tbl  [1 << HIST_BITS];
	ctr_t       pick_tbl [1 << CHOOSER_BITS];
	pht_idx_t   ghist;
	logic       xor_guess;
	logic       cat_guess;
	logic [1:0] mode_q;
	logic       expected_dir [$];
	logic       want;
	int         err_cnt;

	function automatic ctr_t saturate_step(input ctr_t c, input logic up);
		if (up)
			return (c == 2'd3) ? c : c + 2'd1;
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	// Advance the shadow tables by one transaction; return the expected direction bit.
	function automatic logic next_direction(input logic o, input logic [31:0] pc, input logic t);
		pht_idx_t    xi;
		pht_idx_t    ci;
		cho_idx_t    hi;
		logic [31:0] w;
		logic        dir;
		xi = pc[HIST_BITS-1:0] ^ ghist;
		w  = ((pc & SEL_PC_MASK) << SEL_HIST_BITS) | (32'(ghist) & SEL_HIST_MASK);
		ci = w[HIST_BITS-1:0];
		hi = pc[CHOOSER_BITS-1:0];
		if (o == OP_PREDICT) begin
			xor_guess = xor_tbl[xi][1];
			cat_guess = cat_tbl[ci][1];
			case (mode_q)
				MODE_GSHARE:     dir = xor_guess;
				MODE_GSELECT:    dir = cat_guess;
				MODE_TOURNAMENT: dir = pick_tbl[hi][1] ? cat_guess : xor_guess;
				default:         dir = 1'b1;
			endcase
			return dir;
		end
		// always-taken mode leaves every table and the history untouched
		if (mode_q != MODE_ALWAYS) begin
			xor_tbl[xi] = saturate_step(xor_tbl[xi], t);
			cat_tbl[ci] = saturate_step(cat_tbl[ci], t);
			if (xor_guess != cat_guess)
				pick_tbl[hi] = saturate_step(pick_tbl[hi], cat_guess == t);
			ghist = {ghist[HIST_BITS-2:0], t};
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < (1 << HIST_BITS); k++) begin
				xor_tbl[k] = CTR_INIT;
				cat_tbl[k] = CTR_INIT;
			end
			for (int k = 0; k < (1 << CHOOSER_BITS); k++)
				pick_tbl[k] = CTR_INIT;
			ghist     = '0;
			xor_guess = 1'b0;
			cat_guess = 1'b0;
			mode_q    = MODE_ALWAYS;
			expected_dir.delete();
			err_cnt   = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// check the outgoing transaction before queueing the incoming one
			if (out_valid && !out_stall) begin
				if (expected_dir.size() == 0) begin
					$display("%0t: unexpected result, predicted_taken=%0b", $time,
						predicted_taken);
					err_cnt++;
				end else begin
					want = expected_dir.pop_front();
					if (predicted_taken !== want) begin
						$display("%0t: predicted_taken mismatch, expected %0b, actual %0b",
							$time, want, predicted_taken);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_dir.push_back(next_direction(op, branch_pc, resolved_taken));
			if (cfg_wr_en)
				mode_q = cfg_wr_data;
			mismatches <= err_cnt;
			pending    <= expected_dir.size();
		end
	end

endmodule

@@ tb/tb_tournament_branch_predictor_unit.sv @@
`timescale 1ns / 100ps
module tb_tournament_branch_predictor_unit;
	import tbp_pkg::*;

	localparam int IDLE_LIMIT = 60000;
	localparam int LONG_HOLD  = 300;
	localparam int POOL_SIZE  = 16;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        op             = OP_PREDICT;
	logic [31:0] branch_pc      = '0;
	logic        resolved_taken = 1'b0;
	logic        out_stall      = 1'b0;
	logic        cfg_wr_en      = 1'b0;
	logic [1:0]  cfg_wr_data    = MODE_ALWAYS;
	logic        in_stall;
	logic        out_valid;
	logic        predicted_taken;
	int          mismatches;
	int          pending;

	logic        hold_go     = 1'b0;
	int          idle_cycles = 0;
	int          burst_left  = 0;
	int          n_predict   = 0;
	int          n_update    = 0;
	int          n_modes     = 0;

	logic [31:0] pc_pool [POOL_SIZE];
	logic        pc_flip [POOL_SIZE];

	always #10 clk = ~clk;

	tournament_branch_predictor_unit dut (.*);

	tbp_direction_checker chk (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one transaction and hold it until accepted; open a random gap between bursts.
	task automatic offer(input logic o, input logic [31:0] pc, input logic t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid       <= 1'b1;
		op             <= o;
		branch_pc      <= pc;
		resolved_taken <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		if (o == OP_UPDATE)
			n_update++;
		else
			n_predict++;
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		n_modes++;
	endtask

	initial begin : receiver
		int kind;
		int len;
		bit held;
		held = 1'b0;
		forever begin
			if (hold_go && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			kind = $urandom_range(0, 3);
			len  = $urandom_range(5, 60);
			repeat (len) begin
				case (kind)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 99) < 30);
					2:       out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= ~out_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [1:0] mode_seq [7];
		logic       t;
		int         r;
		int         j;
		int         n;
		bit         paused;
		paused = 1'b0;
		for (int k = 0; k < POOL_SIZE; k++) begin
			pc_pool[k] = $urandom();
			pc_flip[k] = 1'b0;
		end
		// alias a few branches onto the same low bits as others
		for (int k = 12; k < POOL_SIZE; k++)
			pc_pool[k] = pc_pool[k-12] ^ ($urandom() << HIST_BITS);
		mode_seq = '{MODE_TOURNAMENT, MODE_GSHARE, MODE_ALWAYS, MODE_GSELECT,
			MODE_TOURNAMENT, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// always-taken from reset: updates must not disturb anything
		offer(OP_PREDICT, 32'h0000_0000, 1'b0);
		offer(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
		offer(OP_UPDATE,  32'h0000_0000, 1'b1);
		offer(OP_UPDATE,  32'hFFFF_FFFF, 1'b0);
		offer(OP_PREDICT, 32'h0000_0000, 1'b0);
		settle();

		// gshare: update with no predict before it, then not-taken updates at one PC
		set_mode(MODE_GSHARE);
		offer(OP_UPDATE,  32'h0000_1234, 1'b1);
		offer(OP_PREDICT, 32'h0000_1234, 1'b0);
		repeat (4) offer(OP_UPDATE, 32'h0000_0000, 1'b0);
		offer(OP_PREDICT, 32'h0000_0000, 1'b1);
		settle();

		set_mode(MODE_GSELECT);
		offer(OP_PREDICT, 32'h0000_007F, 1'b0);
		offer(OP_UPDATE,  32'h0000_007F, 1'b1);
		offer(OP_PREDICT, 32'h0000_0080, 1'b1);
		offer(OP_UPDATE,  32'h0000_0080, 1'b0);
		settle();

		set_mode(MODE_TOURNAMENT);
		offer(OP_PREDICT, 32'h0000_03FF, 1'b0);
		offer(OP_UPDATE,  32'h0000_03FF, 1'b0);
		offer(OP_PREDICT, 32'hFFFF_FC00, 1'b1);
		offer(OP_UPDATE,  32'hFFFF_FC00, 1'b1);
		offer(OP_PREDICT, 32'h0000_03FF, 1'b1);
		offer(OP_UPDATE,  32'h0000_03FF, 1'b0);

		for (int p = 0; p < 7; p++) begin
			settle();
			set_mode(mode_seq[p]);
			if (p == 1)
				hold_go <= 1'b1;
			n = 0;
			while (n < 110) begin
				if (p == 4 && n >= 55 && !paused) begin
					paused = 1'b1;
					settle();
				end
				r = $urandom_range(0, 99);
				if (r < 85) begin
					// predict then resolve the same branch with a per-branch pattern
					j = $urandom_range(0, POOL_SIZE - 1);
					case (j % 4)
						0: t = 1'b1;
						1: t = 1'b0;
						2: begin
							pc_flip[j] = ~pc_flip[j];
							t = pc_flip[j];
						end
						default: t = 1'($urandom_range(0, 1));
					endcase
					offer(OP_PREDICT, pc_pool[j], 1'($urandom_range(0, 1)));
					offer(OP_UPDATE, pc_pool[j], t);
					n += 2;
				end else if (r < 92) begin
					offer(OP_UPDATE, $urandom(), 1'($urandom_range(0, 1)));
					n++;
				end else begin
					offer(OP_PREDICT, $urandom(), 1'($urandom_range(0, 1)));
					n++;
				end
			end
		end

		settle();
		repeat (6) @(posedge clk);
		$display("Covered %0d predict and %0d update transactions over %0d policy writes,",
			n_predict, n_update, n_modes);
		$display("with aliased branches, a long output hold and a mid-run drain.");
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
